[sv/mpe_pkg.sv]
// Shared types, constants and microcode table of the midpoint ellipse quadrant core.
`timescale 1ns / 1ps

package mpe_pkg;

    localparam int RADIUS_BITS_DEF   = 10;
    localparam int DECISION_BITS_DEF = 48;
    localparam int TERM_BITS         = 32;
    localparam int CENTRE_BITS       = 12;
    localparam int POINT_BITS        = 13;
    localparam int CFG_INDEX_BITS    = 2;
    localparam int IN_TDATA_BITS     = 8;
    localparam int OUT_TDATA_BITS    = ((2 * POINT_BITS + 7) / 8) * 8;
    localparam int UPC_BITS          = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_RADIUS_X = 2'd0,
        CFG_RADIUS_Y = 2'd1,
        CFG_CENTRE_X = 2'd2,
        CFG_CENTRE_Y = 2'd3
    } cfg_reg_t;

    typedef logic [UPC_BITS-1:0] upc_t;

    // microcode addresses
    localparam upc_t UPC_RST0 = 4'd0;
    localparam upc_t UPC_RST1 = 4'd1;
    localparam upc_t UPC_RST2 = 4'd2;
    localparam upc_t UPC_STP0 = 4'd3;
    localparam upc_t UPC_STP1 = 4'd4;
    localparam upc_t UPC_R2_0 = 4'd5;
    localparam upc_t UPC_R2_1 = 4'd6;
    localparam upc_t UPC_R2_2 = 4'd7;
    localparam upc_t UPC_R2_3 = 4'd8;
    localparam upc_t UPC_R2_4 = 4'd9;
    localparam upc_t UPC_R2_5 = 4'd10;

    typedef enum logic [1:0] {
        SEQ_NEXT   = 2'd0,
        SEQ_END    = 2'd1,
        SEQ_BRANCH = 2'd2   // jump to target on region change, else end
    } seq_op_t;

    typedef enum logic [2:0] {
        DP_NOP          = 3'd0,
        DP_RST_LOAD     = 3'd1,
        DP_STEP_TERMS   = 3'd2,
        DP_STEP_DEC     = 3'd3,
        DP_DEC_FROM_ACC = 3'd4
    } dp_op_t;

    typedef enum logic [1:0] {
        A_RX2 = 2'd0,
        A_RY2 = 2'd1,
        A_HX  = 2'd2,
        A_YM  = 2'd3
    } a_sel_t;

    typedef enum logic [2:0] {
        B_RY   = 3'd0,
        B_HX   = 3'd1,
        B_YM   = 3'd2,
        B_PROD = 3'd3,
        B_RY2  = 3'd4
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD4 = 2'd2
    } acc_op_t;

    typedef struct packed {
        seq_op_t seq;
        upc_t    target;
        logic    emit;
        dp_op_t  dp;
        logic    mul_en;
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc;
    } ctrl_t;

    typedef struct packed {
        logic fin_next;
        logic enter_r2;
        logic out_full;
    } status_t;

    function automatic ctrl_t ucode(input upc_t pc);
        ctrl_t c;
        c = '{seq: SEQ_NEXT, target: UPC_RST0, emit: 1'b0, dp: DP_NOP, mul_en: 1'b0,
              a_sel: A_RX2, b_sel: B_RY, acc: ACC_HOLD};
        case (pc)
            UPC_RST0: begin
                c.mul_en = 1'b1;
                c.a_sel  = A_RX2;
                c.b_sel  = B_RY;
            end
            UPC_RST1: c.dp = DP_RST_LOAD;
            UPC_RST2: begin
                c.emit = 1'b1;
                c.seq  = SEQ_END;
            end
            UPC_STP0: c.dp = DP_STEP_TERMS;
            UPC_STP1: begin
                c.dp     = DP_STEP_DEC;
                c.emit   = 1'b1;
                c.seq    = SEQ_BRANCH;
                c.target = UPC_R2_0;
            end
            // region-two start: ry2*hx^2 + 4*rx2*ym^2 - 4*rx2*ry2
            UPC_R2_0: begin
                c.mul_en = 1'b1;
                c.a_sel  = A_HX;
                c.b_sel  = B_HX;
            end
            UPC_R2_1: begin
                c.mul_en = 1'b1;
                c.a_sel  = A_RY2;
                c.b_sel  = B_PROD;
            end
            UPC_R2_2: begin
                c.mul_en = 1'b1;
                c.a_sel  = A_YM;
                c.b_sel  = B_YM;
                c.acc    = ACC_LOAD;
            end
            UPC_R2_3: begin
                c.mul_en = 1'b1;
                c.a_sel  = A_RX2;
                c.b_sel  = B_PROD;
            end
            UPC_R2_4: begin
                c.mul_en = 1'b1;
                c.a_sel  = A_RX2;
                c.b_sel  = B_RY2;
                c.acc    = ACC_ADD4;
            end
            UPC_R2_5: begin
                c.dp  = DP_DEC_FROM_ACC;
                c.seq = SEQ_END;
            end
            default: c.seq = SEQ_END;
        endcase
        return c;
    endfunction

endpackage

[sv/mpe_cfg.sv]
// Configuration registers and registered radius squares.
`timescale 1ns / 1ps

module mpe_cfg #(
    parameter int RADIUS_BITS   = mpe_pkg::RADIUS_BITS_DEF,
    parameter int CFG_DATA_BITS = mpe_pkg::CENTRE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [mpe_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]             cfg_data,
    output logic [RADIUS_BITS-1:0]               radius_x,
    output logic [RADIUS_BITS-1:0]               radius_y,
    output logic [2*RADIUS_BITS-1:0]             rx_sq,
    output logic [2*RADIUS_BITS-1:0]             ry_sq,
    output logic [mpe_pkg::CENTRE_BITS-1:0]      centre_x,
    output logic [mpe_pkg::CENTRE_BITS-1:0]      centre_y
);

    logic [RADIUS_BITS-1:0]          rx_reg, rx_next;
    logic [RADIUS_BITS-1:0]          ry_reg, ry_next;
    logic [mpe_pkg::CENTRE_BITS-1:0] cx_reg, cx_next;
    logic [mpe_pkg::CENTRE_BITS-1:0] cy_reg, cy_next;
    logic [2*RADIUS_BITS-1:0]        rx_sq_reg, rx_sq_next;
    logic [2*RADIUS_BITS-1:0]        ry_sq_reg, ry_sq_next;

    always_comb
    begin
        rx_next = rx_reg;
        ry_next = ry_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        if (cfg_wr_en)
        begin
            case (mpe_pkg::cfg_reg_t'(cfg_index))
                mpe_pkg::CFG_RADIUS_X: rx_next = cfg_data[RADIUS_BITS-1:0];
                mpe_pkg::CFG_RADIUS_Y: ry_next = cfg_data[RADIUS_BITS-1:0];
                mpe_pkg::CFG_CENTRE_X: cx_next = cfg_data[mpe_pkg::CENTRE_BITS-1:0];
                mpe_pkg::CFG_CENTRE_Y: cy_next = cfg_data[mpe_pkg::CENTRE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // squares are loaded on the same edge as the radii
    assign rx_sq_next = {{RADIUS_BITS{1'b0}}, rx_next} * {{RADIUS_BITS{1'b0}}, rx_next};
    assign ry_sq_next = {{RADIUS_BITS{1'b0}}, ry_next} * {{RADIUS_BITS{1'b0}}, ry_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg    <= RADIUS_BITS'(1);
            ry_reg    <= RADIUS_BITS'(1);
            cx_reg    <= '0;
            cy_reg    <= '0;
            rx_sq_reg <= (2*RADIUS_BITS)'(1);
            ry_sq_reg <= (2*RADIUS_BITS)'(1);
        end
        else
        begin
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            rx_sq_reg <= rx_sq_next;
            ry_sq_reg <= ry_sq_next;
        end
    end

    assign radius_x = rx_reg;
    assign radius_y = ry_reg;
    assign rx_sq    = rx_sq_reg;
    assign ry_sq    = ry_sq_reg;
    assign centre_x = cx_reg;
    assign centre_y = cy_reg;

endmodule

[sv/mpe_seq.sv]
// Microcode sequencer: step counter, dispatch of requests and branch control.
`timescale 1ns / 1ps

module mpe_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             restart,
    input  mpe_pkg::status_t status,
    output mpe_pkg::ctrl_t   ctrl,
    output logic             run
);

    logic            busy_reg, busy_next;
    mpe_pkg::upc_t   pc_reg, pc_next;
    logic            stall;
    logic            item_end;
    logic            accept;

    assign ctrl  = mpe_pkg::ucode(pc_reg);
    assign stall = ctrl.emit && status.out_full;
    assign run   = busy_reg && !stall;

    assign item_end = run && ((ctrl.seq == mpe_pkg::SEQ_END) ||
                              ((ctrl.seq == mpe_pkg::SEQ_BRANCH) && !status.enter_r2));

    // next request may be taken in the last step of the current one
    assign s_tready = !busy_reg || item_end;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (accept)
        begin
            if (restart)
            begin
                busy_next = 1'b1;
                pc_next   = mpe_pkg::UPC_RST0;
            end
            else if (!status.fin_next)
            begin
                busy_next = 1'b1;
                pc_next   = mpe_pkg::UPC_STP0;
            end
            else
            begin
                busy_next = 1'b0;   // step after the last point: no result
            end
        end
        else if (run)
        begin
            case (ctrl.seq)
                mpe_pkg::SEQ_NEXT: pc_next = pc_reg + mpe_pkg::upc_t'(1);
                mpe_pkg::SEQ_END:  busy_next = 1'b0;
                mpe_pkg::SEQ_BRANCH:
                begin
                    if (status.enter_r2)
                        pc_next = ctrl.target;
                    else
                        busy_next = 1'b0;
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= mpe_pkg::UPC_RST0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

[sv/mpe_dp.sv]
// Datapath: offsets, terms, decision, shared multiplier, accumulator and output register.
`timescale 1ns / 1ps

module mpe_dp #(
    parameter int RADIUS_BITS   = mpe_pkg::RADIUS_BITS_DEF,
    parameter int DECISION_BITS = mpe_pkg::DECISION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mpe_pkg::ctrl_t                       ctrl,
    input  logic                                 run,
    input  logic [RADIUS_BITS-1:0]               radius_y,
    input  logic [2*RADIUS_BITS-1:0]             rx_sq,
    input  logic [2*RADIUS_BITS-1:0]             ry_sq,
    input  logic [mpe_pkg::CENTRE_BITS-1:0]      centre_x,
    input  logic [mpe_pkg::CENTRE_BITS-1:0]      centre_y,
    input  logic                                 m_tready,
    output mpe_pkg::status_t                     status,
    output logic                                 m_tvalid,
    output logic [mpe_pkg::POINT_BITS-1:0]       point_x,
    output logic [mpe_pkg::POINT_BITS-1:0]       point_y,
    output logic                                 last_point
);

    localparam int R  = RADIUS_BITS;
    localparam int D  = DECISION_BITS;
    localparam int TB = mpe_pkg::TERM_BITS;
    localparam int PB = mpe_pkg::POINT_BITS;
    localparam int CB = mpe_pkg::CENTRE_BITS;
    // wide enough for any product here without loss, and for the decision
    localparam int PW = (D > 4*R+2) ? D : 4*R+2;
    // multiplier operands: a squared radius, and at most hx^2
    localparam int AW = 2*R;
    localparam int BW = 2*R+2;
    localparam int MW = 4*R+2;

    logic [R-1:0]  ox_reg, ox_next;
    logic [R-1:0]  oy_reg, oy_next;
    logic [TB-1:0] tx_reg, tx_next;
    logic [TB-1:0] ty_reg, ty_next;
    logic [D-1:0]  dec_reg, dec_next;
    logic [D-1:0]  acc_reg, acc_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic          dx_reg, dx_next;
    logic          dy_reg, dy_next;
    logic          r2_reg, r2_next;
    logic          fin_reg, fin_next;
    logic          out_valid_reg, out_valid_next;
    logic [PB-1:0] px_reg, px_next;
    logic [PB-1:0] py_reg, py_next;
    logic          last_reg, last_next;

    logic [R:0]    hx;
    logic [R-1:0]  ym;
    logic [AW-1:0] a_ext;
    logic [BW-1:0] b_ext;
    logic [MW-1:0] mul_out;
    logic [TB-1:0] two_rx_sq, two_ry_sq;
    logic [D-1:0]  rx_sq_d, ry_sq_d, prod_d, base_d, tx_d, ty_d, sum_d;
    logic          neg;
    logic          step_dx, step_dy;
    logic          enter_r2;
    logic          emit_fire;

    assign hx        = {ox_reg, 1'b1};
    assign ym        = oy_reg - R'(1);
    assign two_rx_sq = TB'({rx_sq, 1'b0});
    assign two_ry_sq = TB'({ry_sq, 1'b0});
    assign rx_sq_d   = D'(rx_sq);
    assign ry_sq_d   = D'(ry_sq);
    assign prod_d    = D'(prod_reg);
    assign neg       = dec_reg[D-1];

    // region one always moves x, region two always moves y
    assign step_dx = r2_reg ? neg  : 1'b1;
    assign step_dy = r2_reg ? 1'b1 : !neg;

    assign base_d = r2_reg ? rx_sq_d : ry_sq_d;
    assign tx_d   = dx_reg ? D'(tx_reg) : '0;
    assign ty_d   = dy_reg ? D'(ty_reg) : '0;
    assign sum_d  = base_d + tx_d - ty_d;

    assign enter_r2 = !r2_reg && (oy_reg != '0) && (ty_reg < tx_reg);

    always_comb
    begin
        case (ctrl.a_sel)
            mpe_pkg::A_RX2: a_ext = rx_sq;
            mpe_pkg::A_RY2: a_ext = ry_sq;
            mpe_pkg::A_HX:  a_ext = AW'(hx);
            mpe_pkg::A_YM:  a_ext = AW'(ym);
            default:        a_ext = '0;
        endcase
        case (ctrl.b_sel)
            mpe_pkg::B_RY:   b_ext = BW'(radius_y);
            mpe_pkg::B_HX:   b_ext = BW'(hx);
            mpe_pkg::B_YM:   b_ext = BW'(ym);
            mpe_pkg::B_PROD: b_ext = prod_reg[BW-1:0];
            mpe_pkg::B_RY2:  b_ext = BW'(ry_sq);
            default:         b_ext = '0;
        endcase
    end

    assign mul_out = MW'(a_ext) * MW'(b_ext);

    always_comb
    begin
        prod_next = prod_reg;
        if (run && ctrl.mul_en)
            prod_next = PW'(mul_out);

        acc_next = acc_reg;
        if (run)
        begin
            case (ctrl.acc)
                mpe_pkg::ACC_LOAD: acc_next = prod_d;
                mpe_pkg::ACC_ADD4: acc_next = acc_reg + D'(prod_reg << 2);
                default:           acc_next = acc_reg;
            endcase
        end
    end

    always_comb
    begin
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        tx_next  = tx_reg;
        ty_next  = ty_reg;
        dec_next = dec_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        r2_next  = r2_reg;
        fin_next = fin_reg;
        if (run)
        begin
            case (ctrl.dp)
                mpe_pkg::DP_RST_LOAD:
                begin
                    // prod holds rx2*ry
                    ox_next  = '0;
                    oy_next  = radius_y;
                    tx_next  = '0;
                    ty_next  = TB'(prod_reg << 1);
                    dec_next = (ry_sq_d << 2) - (prod_d << 2) + rx_sq_d;
                    r2_next  = 1'b0;
                    fin_next = (radius_y == '0);
                end
                mpe_pkg::DP_STEP_TERMS:
                begin
                    dx_next = step_dx;
                    dy_next = step_dy;
                    if (step_dx)
                    begin
                        ox_next = ox_reg + R'(1);
                        tx_next = tx_reg + two_ry_sq;
                    end
                    if (step_dy)
                    begin
                        oy_next = oy_reg - R'(1);
                        ty_next = ty_reg - two_rx_sq;
                    end
                end
                mpe_pkg::DP_STEP_DEC:
                begin
                    // terms already hold their updated values
                    dec_next = dec_reg + (sum_d << 2);
                    fin_next = fin_reg || (oy_reg == '0);
                    if (enter_r2)
                        r2_next = 1'b1;
                end
                mpe_pkg::DP_DEC_FROM_ACC: dec_next = acc_reg - D'(prod_reg << 2);
                default: ;
            endcase
        end
    end

    // output register
    assign emit_fire      = run && ctrl.emit;
    assign out_valid_next = emit_fire || (out_valid_reg && !m_tready);
    assign px_next  = emit_fire ? PB'(ox_reg) + {centre_x[CB-1], centre_x} : px_reg;
    assign py_next  = emit_fire ? PB'(oy_reg) + {centre_y[CB-1], centre_y} : py_reg;
    assign last_next = emit_fire ? (oy_reg == '0) : last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_reg        <= 1'b0;
            fin_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            r2_reg        <= r2_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        tx_reg   <= tx_next;
        ty_reg   <= ty_next;
        dec_reg  <= dec_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
    end

    assign status.fin_next = fin_next;
    assign status.enter_r2 = enter_r2;
    assign status.out_full = out_valid_reg && !m_tready;

    assign m_tvalid   = out_valid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign last_point = last_reg;

endmodule

[sv/midpoint_ellipse_quadrant_core.sv]
// Ordinary step: microcode steps STP0 (terms) and STP1 (decision, output register load);
// the next request may be taken in STP1. Restart: steps RST0 to RST2. The step that crosses
// into region two runs on from STP1, as the shared multiplier works out the region-two start
// decision over six microcode steps. A step after the last point is accepted and gives no result.
// Reset (rst_n low, asynchronous): rx = ry = 1, centre 0, idle until a restart request.
`timescale 1ns / 1ps

module midpoint_ellipse_quadrant_core #(
    parameter int RADIUS_BITS   = mpe_pkg::RADIUS_BITS_DEF,
    parameter int DECISION_BITS = mpe_pkg::DECISION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mpe_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [0] restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mpe_pkg::OUT_TDATA_BITS-1:0]  m_tdata,   // [12:0] point_x, [25:13] point_y
    output logic                                m_tlast,   // last_point
    input  logic                                cfg_wr_en,
    input  logic [mpe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [((RADIUS_BITS > mpe_pkg::CENTRE_BITS) ? RADIUS_BITS
                   : mpe_pkg::CENTRE_BITS)-1:0] cfg_data
);

    localparam int CFG_DATA_BITS = (RADIUS_BITS > mpe_pkg::CENTRE_BITS) ? RADIUS_BITS
                                                                         : mpe_pkg::CENTRE_BITS;
    localparam int PB = mpe_pkg::POINT_BITS;

    logic [RADIUS_BITS-1:0]          radius_x;
    logic [RADIUS_BITS-1:0]          radius_y;
    logic [2*RADIUS_BITS-1:0]        rx_sq;
    logic [2*RADIUS_BITS-1:0]        ry_sq;
    logic [mpe_pkg::CENTRE_BITS-1:0] centre_x;
    logic [mpe_pkg::CENTRE_BITS-1:0] centre_y;
    mpe_pkg::ctrl_t                  ctrl;
    mpe_pkg::status_t                status;
    logic                            run;
    logic [PB-1:0]                   point_x;
    logic [PB-1:0]                   point_y;

    mpe_cfg #(
        .RADIUS_BITS   (RADIUS_BITS),
        .CFG_DATA_BITS (CFG_DATA_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .radius_x  (radius_x),
        .radius_y  (radius_y),
        .rx_sq     (rx_sq),
        .ry_sq     (ry_sq),
        .centre_x  (centre_x),
        .centre_y  (centre_y)
    );

    mpe_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .status   (status),
        .ctrl     (ctrl),
        .run      (run)
    );

    mpe_dp #(
        .RADIUS_BITS   (RADIUS_BITS),
        .DECISION_BITS (DECISION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .run        (run),
        .radius_y   (radius_y),
        .rx_sq      (rx_sq),
        .ry_sq      (ry_sq),
        .centre_x   (centre_x),
        .centre_y   (centre_y),
        .m_tready   (m_tready),
        .status     (status),
        .m_tvalid   (m_tvalid),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (m_tlast)
    );

    // radius_x itself is unused here; the squarer inside the config block works from rx_next
    logic unused_rx;
    assign unused_rx = ^radius_x;

    assign m_tdata = {(mpe_pkg::OUT_TDATA_BITS - 2*PB)'(unused_rx & 1'b0), point_y, point_x};

endmodule
